### design/line_segment_outcode_clipper_assert.svh
// assertion macros for the line segment clipper
// no dependencies; included by modules that check their own logic
`ifndef LINE_SEGMENT_OUTCODE_CLIPPER_ASSERT_SVH
`define LINE_SEGMENT_OUTCODE_CLIPPER_ASSERT_SVH
`define LSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`endif

### design/lsc_pkg.sv
// shared types and constants for the line segment clipper
// no dependencies
package lsc_pkg;
  localparam int FracBits = 8;
  localparam int InW = 24;
  localparam int CoordW = 15;
  localparam int MaxPasses = 16;
  localparam int PassW = 5;
  localparam int DiffW = InW + 1;
  localparam int ProdW = 2 * DiffW;
  localparam int DivSteps = ProdW;

  localparam logic [1:0] RegMinX = 2'd0;
  localparam logic [1:0] RegMaxX = 2'd1;
  localparam logic [1:0] RegMinY = 2'd2;
  localparam logic [1:0] RegMaxY = 2'd3;

  localparam logic [3:0] CodeTop = 4'd8;
  localparam logic [3:0] CodeBottom = 4'd4;
  localparam logic [3:0] CodeRight = 4'd2;
  localparam logic [3:0] CodeLeft = 4'd1;

  typedef struct packed {
    logic signed [InW-1:0] start_x_in;
    logic signed [InW-1:0] start_y_in;
    logic signed [InW-1:0] end_x_in;
    logic signed [InW-1:0] end_y_in;
  } in_item_t;

  typedef struct packed {
    logic              visible;
    logic [CoordW-1:0] start_x_out;
    logic [CoordW-1:0] start_y_out;
    logic [CoordW-1:0] end_x_out;
    logic [CoordW-1:0] end_y_out;
  } out_item_t;

  typedef struct packed {
    logic [CoordW-1:0] min_x;
    logic [CoordW-1:0] max_x;
    logic [CoordW-1:0] min_y;
    logic [CoordW-1:0] max_y;
  } window_t;

  // queued work item: segment plus the outcodes found at entry
  typedef struct packed {
    in_item_t  seg;
    logic [3:0] c1;
    logic [3:0] c2;
  } job_t;

  function automatic logic [3:0] outcode(input logic signed [InW-1:0] x,
                                         input logic signed [InW-1:0] y,
                                         input window_t w);
    logic signed [InW:0] xmin, xmax, ymin, ymax;
    logic [3:0] c;
    xmin = $signed({2'b00, w.min_x, {FracBits{1'b0}}});
    xmax = $signed({2'b00, w.max_x, {FracBits{1'b0}}});
    ymin = $signed({2'b00, w.min_y, {FracBits{1'b0}}});
    ymax = $signed({2'b00, w.max_y, {FracBits{1'b0}}});
    c = '0;
    if ($signed({y[InW-1], y}) > ymax) c = c | CodeTop;
    if ($signed({y[InW-1], y}) < ymin) c = c | CodeBottom;
    if ($signed({x[InW-1], x}) > xmax) c = c | CodeRight;
    if ($signed({x[InW-1], x}) < xmin) c = c | CodeLeft;
    return c;
  endfunction
endpackage

### design/lsc_front.sv
// front end: accepts segments, classifies them and queues them
// depends on lsc_pkg
module lsc_front import lsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  window_t  win_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     job_valid_o,
  input  logic     job_ready_i,
  output job_t     job_o
);
  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = job_valid_o && job_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q].seg <= in_data_i;
      mem_q[wp_q].c1  <= outcode(in_data_i.start_x_in, in_data_i.start_y_in, win_i);
      mem_q[wp_q].c2  <= outcode(in_data_i.end_x_in, in_data_i.end_y_in, win_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### design/lsc_back.sv
// back end: clip loop with a serial divider and an output register
// depends on lsc_pkg and the assertion macro header
`include "line_segment_outcode_clipper_assert.svh"
module lsc_back import lsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  window_t   win_i,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  job_t      job_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);
  typedef enum logic [2:0] {S_IDLE, S_TEST, S_MUL, S_DIV, S_FIX} state_e;

  state_e state_q;
  logic signed [InW-1:0] x1_q, y1_q, x2_q, y2_q;
  logic [3:0] c1_q, c2_q;
  logic [PassW-1:0] pass_q;
  logic [ProdW-1:0] rem_q, quo_q, den_q;
  logic [$clog2(DivSteps+1)-1:0] step_q;
  logic neg_q, vert_q;
  logic signed [InW:0] edge_q;
  logic signed [InW-1:0] base_q;
  logic out_valid_q;
  out_item_t out_q;

  logic signed [InW:0] emin_x, emax_x, emin_y, emax_y;
  logic signed [DiffW-1:0] dx, dy, num_a, den_b;
  logic signed [DiffW:0] ediff;
  logic signed [ProdW-1:0] prod;
  logic [ProdW-1:0] rem_sh, mag_num, mag_den;
  logic signed [ProdW-1:0] qsig, moved;

  assign emin_x = $signed({2'b00, win_i.min_x, {FracBits{1'b0}}});
  assign emax_x = $signed({2'b00, win_i.max_x, {FracBits{1'b0}}});
  assign emin_y = $signed({2'b00, win_i.min_y, {FracBits{1'b0}}});
  assign emax_y = $signed({2'b00, win_i.max_y, {FracBits{1'b0}}});

  assign dx = $signed({x2_q[InW-1], x2_q}) - $signed({x1_q[InW-1], x1_q});
  assign dy = $signed({y2_q[InW-1], y2_q}) - $signed({y1_q[InW-1], y1_q});
  // vertical edges move y along dy/dx, horizontal edges move x along dx/dy
  assign num_a = vert_q ? dy : dx;
  assign den_b = vert_q ? dx : dy;
  assign ediff = $signed({edge_q[InW], edge_q}) -
                 (vert_q ? $signed({{2{x1_q[InW-1]}}, x1_q})
                         : $signed({{2{y1_q[InW-1]}}, y1_q}));
  assign prod = num_a * $signed(ediff[DiffW-1:0]);
  assign mag_num = prod[ProdW-1] ? ProdW'(-prod) : prod;
  assign mag_den = den_b[DiffW-1] ? ProdW'(-{{DiffW{den_b[DiffW-1]}}, den_b})
                                  : ProdW'({{DiffW{1'b0}}, den_b});
  assign rem_sh = {rem_q[ProdW-2:0], quo_q[ProdW-1]};
  assign qsig = neg_q ? -$signed(quo_q) : $signed(quo_q);
  assign moved = qsig + ProdW'(base_q);

  assign job_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      pass_q <= '0;
      step_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (job_valid_i && job_ready_o) begin
            x1_q <= job_i.seg.start_x_in;
            y1_q <= job_i.seg.start_y_in;
            x2_q <= job_i.seg.end_x_in;
            y2_q <= job_i.seg.end_y_in;
            c1_q <= job_i.c1;
            c2_q <= job_i.c2;
            pass_q <= '0;
            state_q <= S_TEST;
          end
        end
        S_TEST: begin
          if ((c1_q | c2_q) == 4'd0 && pass_q != PassW'(MaxPasses)) begin
            out_q.visible <= 1'b1;
            out_q.start_x_out <= x1_q[FracBits +: CoordW];
            out_q.start_y_out <= y1_q[FracBits +: CoordW];
            out_q.end_x_out <= x2_q[FracBits +: CoordW];
            out_q.end_y_out <= y2_q[FracBits +: CoordW];
            out_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end else if ((c1_q & c2_q) != 4'd0 || pass_q == PassW'(MaxPasses)) begin
            out_q <= '0;
            out_valid_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            logic [3:0] c;
            c = c1_q;
            if (c1_q == 4'd0) begin
              x1_q <= x2_q; y1_q <= y2_q; x2_q <= x1_q; y2_q <= y1_q;
              c1_q <= c2_q; c2_q <= c1_q;
              c = c2_q;
            end
            if ((c & CodeTop) != 0) begin
              vert_q <= 1'b0; edge_q <= emax_y;
            end else if ((c & CodeBottom) != 0) begin
              vert_q <= 1'b0; edge_q <= emin_y;
            end else if ((c & CodeRight) != 0) begin
              vert_q <= 1'b1; edge_q <= emax_x;
            end else begin
              vert_q <= 1'b1; edge_q <= emin_x;
            end
            pass_q <= pass_q + 1'b1;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          quo_q <= mag_num;
          rem_q <= '0;
          den_q <= mag_den;
          neg_q <= prod[ProdW-1] ^ den_b[DiffW-1];
          base_q <= vert_q ? y1_q : x1_q;
          step_q <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (rem_sh >= den_q) begin
            rem_q <= rem_sh - den_q;
            quo_q <= {quo_q[ProdW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[ProdW-2:0], 1'b0};
          end
          step_q <= step_q + 1'b1;
          if (step_q == ($bits(step_q))'(DivSteps - 1)) state_q <= S_FIX;
        end
        S_FIX: begin
          if (vert_q) begin
            y1_q <= moved[InW-1:0];
            x1_q <= edge_q[InW-1:0];
            c1_q <= outcode(edge_q[InW-1:0], moved[InW-1:0], win_i);
          end else begin
            x1_q <= moved[InW-1:0];
            y1_q <= edge_q[InW-1:0];
            c1_q <= outcode(moved[InW-1:0], edge_q[InW-1:0], win_i);
          end
          state_q <= S_TEST;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `LSC_ASSERT(a_take_idle, job_valid_i && job_ready_o |=> state_q == S_TEST)
  `LSC_ASSERT(a_pass_cap, pass_q <= PassW'(MaxPasses))
  `LSC_ASSERT(a_div_nz, state_q == S_DIV |-> den_q != '0)
  `LSC_ASSERT(a_rej_zero, out_valid_o && !out_data_o.visible |-> out_data_o.start_x_out == '0)
endmodule

### design/line_segment_outcode_clipper.sv
// Cohen-Sutherland line clipper: a segment that is trivially accepted or rejected
// needs only the outcode test; each clip pass adds a multiply, a 50-step
// restoring divider and a fix-up, at most 4 passes in practice (cap 16); the
// serial divider sets the rate. A two-entry queue decouples input from clipping.
// depends on lsc_pkg, lsc_front and lsc_back
module line_segment_outcode_clipper import lsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);
  window_t win_q;
  logic    job_valid, job_ready;
  job_t    job;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q.min_x <= '0;
      win_q.max_x <= '1;
      win_q.min_y <= '0;
      win_q.max_y <= '1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegMinX: win_q.min_x <= pwdata[CoordW-1:0];
        RegMaxX: win_q.max_x <= pwdata[CoordW-1:0];
        RegMinY: win_q.min_y <= pwdata[CoordW-1:0];
        RegMaxY: win_q.max_y <= pwdata[CoordW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegMinX: prdata = {17'd0, win_q.min_x};
      RegMaxX: prdata = {17'd0, win_q.max_x};
      RegMinY: prdata = {17'd0, win_q.min_y};
      RegMaxY: prdata = {17'd0, win_q.max_y};
      default: prdata = '0;
    endcase
  end

  lsc_front u_front (
    .clk_i, .rst_ni, .win_i(win_q),
    .in_valid_i, .in_ready_o, .in_data_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  lsc_back u_back (
    .clk_i, .rst_ni, .win_i(win_q),
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule

### tb/sv/lsc_checker.sv
// checker for the line segment clipper: watches the segment and result channels,
// predicts each clipped result and compares it field by field
// depends on lsc_pkg
module lsc_checker import lsc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  input  window_t   win_i,
  output int        errors_o,
  output int        pending_o
);
  out_item_t clipped_q[$];

  function automatic logic [3:0] region_code(longint x, longint y, longint xl, longint xh,
                                             longint yl, longint yh);
    logic [3:0] c;
    c = '0;
    if (y > yh) c |= CodeTop;
    if (y < yl) c |= CodeBottom;
    if (x > xh) c |= CodeRight;
    if (x < xl) c |= CodeLeft;
    return c;
  endfunction

  function automatic longint cross_edge(longint a, longint da, longint e, longint b,
                                        longint db);
    if (db == 0) return a;
    return a + (da * (e - b)) / db;
  endfunction

  function automatic out_item_t clip_segment(in_item_t s, window_t w);
    longint x1, y1, x2, y2, xl, xh, yl, yh, t;
    logic [3:0] c1, c2;
    out_item_t r;
    x1 = longint'(s.start_x_in);
    y1 = longint'(s.start_y_in);
    x2 = longint'(s.end_x_in);
    y2 = longint'(s.end_y_in);
    xl = longint'(w.min_x) <<< FracBits;
    xh = longint'(w.max_x) <<< FracBits;
    yl = longint'(w.min_y) <<< FracBits;
    yh = longint'(w.max_y) <<< FracBits;
    r = '0;
    for (int p = 0; p < MaxPasses; p++) begin
      c1 = region_code(x1, y1, xl, xh, yl, yh);
      c2 = region_code(x2, y2, xl, xh, yl, yh);
      if ((c1 | c2) == 0) begin
        r.visible = 1'b1;
        r.start_x_out = CoordW'(x1 >>> FracBits);
        r.start_y_out = CoordW'(y1 >>> FracBits);
        r.end_x_out = CoordW'(x2 >>> FracBits);
        r.end_y_out = CoordW'(y2 >>> FracBits);
        return r;
      end
      if ((c1 & c2) != 0) return r;
      if (c1 == 0) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
        c1 = c2;
      end
      if ((c1 & CodeTop) != 0) begin
        x1 = cross_edge(x1, x2 - x1, yh, y1, y2 - y1);
        y1 = yh;
      end else if ((c1 & CodeBottom) != 0) begin
        x1 = cross_edge(x1, x2 - x1, yl, y1, y2 - y1);
        y1 = yl;
      end else if ((c1 & CodeRight) != 0) begin
        y1 = cross_edge(y1, y2 - y1, xh, x1, x2 - x1);
        x1 = xh;
      end else begin
        y1 = cross_edge(y1, y2 - y1, xl, x1, x2 - x1);
        x1 = xl;
      end
    end
    return r;
  endfunction

  initial errors_o = 0;
  assign pending_o = clipped_q.size();

  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) clipped_q.push_back(clip_segment(in_data_i, win_i));
      if (out_valid_i && out_ready_i) begin
        if (clipped_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = clipped_q.pop_front();
          if (exp_r.visible !== out_data_i.visible ||
              exp_r.start_x_out !== out_data_i.start_x_out ||
              exp_r.start_y_out !== out_data_i.start_y_out ||
              exp_r.end_x_out !== out_data_i.end_x_out ||
              exp_r.end_y_out !== out_data_i.end_y_out) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, out_data_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

### tb/sv/line_segment_outcode_clipper_tb.sv
// testbench top for the line segment clipper: drives segments and window
// registers, stalls the result side, and reports the verdict
// depends on lsc_pkg, lsc_checker and the clipper
module line_segment_outcode_clipper_tb;
  import lsc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  window_t win = '{min_x: 15'd0, max_x: 15'h7fff, min_y: 15'd0, max_y: 15'h7fff};
  int errors, pending;
  int cycles = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  always #1 clk_i = ~clk_i;

  line_segment_outcode_clipper u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .in_data_i, .out_valid_o, .out_ready_i, .out_data_o
  );

  lsc_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o), .win_i(win),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= quiet || ($urandom_range(99) >= 17);
  end

  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= {17'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegMinX: win.min_x = val;
      RegMaxX: win.max_x = val;
      RegMinY: win.min_y = val;
      default: win.max_y = val;
    endcase
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_window(logic [14:0] xl, logic [14:0] xh, logic [14:0] yl,
                            logic [14:0] yh);
    write_reg(RegMinX, xl);
    write_reg(RegMaxX, xh);
    write_reg(RegMinY, yl);
    write_reg(RegMaxY, yh);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send(in_item_t s);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 17) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic logic signed [23:0] near_coord(logic [14:0] lo, logic [14:0] hi);
    int span;
    span = (int'(hi) - int'(lo)) * 256;
    if (span < 0) span = -span;
    return 24'(int'(lo) * 256 - 4096 + int'($urandom_range(span + 8192)));
  endfunction

  function automatic in_item_t rand_segment();
    in_item_t s;
    if ($urandom_range(3) == 0) begin
      s = {$urandom, $urandom, $urandom};
    end else begin
      s.start_x_in = near_coord(win.min_x, win.max_x);
      s.start_y_in = near_coord(win.min_y, win.max_y);
      s.end_x_in = near_coord(win.min_x, win.max_x);
      s.end_y_in = near_coord(win.min_y, win.max_y);
    end
    return s;
  endfunction

  task automatic directed();
    logic signed [23:0] lo, hi, mid;
    lo = 24'sh800000; hi = 24'sh7fffff; mid = 24'sh001000;
    send('{mid, mid, 24'sh002000, 24'sh003000});
    send('{lo, lo, hi, hi});
    send('{hi, lo, lo, hi});
    send('{lo, mid, lo, hi});
    send('{hi, hi, hi, mid});
    send('{mid, hi, mid, lo});
    send('{lo, mid, hi, mid});
    send('{mid, mid, hi, hi});
    send('{hi, hi, mid, mid});
    send('{24'sh0, 24'sh0, 24'sh0, 24'sh0});
    send('{24'shffffff, 24'sh0, 24'sh100, 24'shffffff});
    send('{lo, 24'sh010000, 24'sh050000, hi});
    drain();
    set_window(15'd100, 15'd200, 15'd50, 15'd300);
    send('{24'sh000000, 24'sh000000, 24'sh020000, 24'sh020000});
    send('{24'sh00c000, 24'sh000000, 24'sh00c000, 24'sh020000});
    send('{24'sh000000, 24'sh008000, 24'sh000000, 24'sh010000});
    send('{24'sh008000, 24'sh008000, 24'sh00a000, 24'sh00b000});
    send('{24'sh000100, 24'sh020000, 24'sh00ff00, 24'sh000300});
    drain();
    set_window(15'd300, 15'd100, 15'd50, 15'd300);
    send('{24'sh00c000, 24'sh008000, 24'sh00c800, 24'sh009000});
    drain();
    set_window(15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
    send('{24'sh7fff00, 24'sh7fff00, 24'sh7fff80, 24'sh7fffff});
    send('{24'sh7f0000, 24'sh7f0000, 24'sh7fffff, 24'sh7fffff});
    drain();
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    set_window(15'd0, 15'h7fff, 15'd0, 15'h7fff);
    directed();
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: set_window(15'd0, 15'd0, 15'd0, 15'd0);
        1: set_window(15'd10, 15'd40, 15'd20, 15'd60);
        2: set_window(15'd0, 15'h7fff, 15'd0, 15'h7fff);
        3: set_window(15'd500, 15'd499, 15'd10, 15'd90);
        default: set_window(15'($urandom_range(200)), 15'($urandom_range(200, 600)),
                            15'($urandom_range(200)), 15'($urandom_range(200, 600)));
      endcase
      n = (ph == 0) ? 30 : 145;
      quiet = (ph == 5);
      if (ph == 2) fork
        begin
          hold_off = 1'b1;
          repeat (600) @(posedge clk_i);
          hold_off = 1'b0;
        end
      join_none
      for (int i = 0; i < n; i++) begin
        send(rand_segment());
        if (ph == 6 && i == 70) drain();
      end
      quiet = 1'b0;
    end
    drain();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

### filelist.f
+incdir+design
design/lsc_pkg.sv
design/lsc_front.sv
design/lsc_back.sv
design/line_segment_outcode_clipper.sv
tb/sv/lsc_checker.sv
tb/sv/line_segment_outcode_clipper_tb.sv
